// ===== rtl/core/cpra_pkg.sv =====
// Shared codes and types for the contiguous page run allocator.
`default_nettype none
package cpra_pkg;

    // Lazy cover tags held in every tree node
    localparam logic [1:0] TAG_NONE = 2'd0;
    localparam logic [1:0] TAG_USED = 2'd1;
    localparam logic [1:0] TAG_FREE = 2'd2;

    // Request operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Tree engine command codes
    localparam logic TOP_SEARCH = 1'b0;
    localparam logic TOP_UPDATE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_PSL   = 2'd1;
    localparam logic [1:0] CFG_TOTAL = 2'd2;

    // Largest usable page size exponent
    localparam logic [4:0] MAX_LOG2 = 5'd20;

    // Status returned by the tree engine
    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } t_tree_stat;

endpackage
`default_nettype wire

// ===== rtl/core/contiguous_page_run_allocator.sv =====
// Top level: request handshake, configuration, run length store and tree engine.
//
// Usage: requests enter on the input channel (i_in_valid / o_in_stall) with
// i_operation, i_request_bytes and i_free_address. Each request yields exactly
// one result on the output channel (o_out_valid / i_out_stall) carrying
// o_address and o_failed. An allocate rounds its size up to pages, finds a
// fitting free run in the segment tree, marks it used and records its
// length; a free clears a previously recorded run.
// One request is processed at a time. A request rejected by the first checks
// skips the tree engine. The search pushes down a lazy tag where one is held
// and then reads both children on each tree level; the range cover splits
// nodes on its way down and rebuilds them on its way up. The walks are paced
// by the node RAM, which serves one read and one write per cycle.
// A finished result sits in the output register; the next request is taken
// while it waits, and its own result holds until the receiver stops stalling.
// Reset, and any write of total_pages, starts a clearing pass over every entry
// of the run length store; no request is taken meanwhile, while
// configuration writes are taken as ever. Configure only while idle.
`default_nettype none
module contiguous_page_run_allocator
    import cpra_pkg::*;
#(
    parameter int MAX_PAGES = 2048
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_operation,
    input  wire logic [31:0] i_request_bytes,
    input  wire logic [31:0] i_free_address,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [31:0] o_address,
    output logic             o_failed,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int PW = $clog2(MAX_PAGES + 1);
    localparam int IW = $clog2(MAX_PAGES);
    localparam int TOTAL_RST = (MAX_PAGES < 2048) ? MAX_PAGES : 2048;

    localparam logic [2:0] T_CLEAR = 3'd0;
    localparam logic [2:0] T_IDLE  = 3'd1;
    localparam logic [2:0] T_PREP  = 3'd2;
    localparam logic [2:0] T_CHK   = 3'd3;
    localparam logic [2:0] T_FLEN  = 3'd4;
    localparam logic [2:0] T_SRCH  = 3'd5;
    localparam logic [2:0] T_UPD   = 3'd6;
    localparam logic [2:0] T_DONE  = 3'd7;

    logic [2:0]    r_state;
    logic [31:0]   r_base;
    logic [4:0]    r_psl;
    logic [PW-1:0] r_total;
    logic [IW-1:0] r_clr;
    logic          r_init;
    logic          r_op;
    logic [31:0]   r_bytes, r_faddr, r_pg;
    logic [32:0]   r_need;
    logic          r_go, r_top;
    logic [IW-1:0] r_ua, r_ub;
    logic [1:0]    r_utag;
    logic [31:0]   r_res_addr;
    logic          r_res_fail;
    logic          r_ov;
    logic [31:0]   r_oaddr;
    logic          r_ofail;

    logic [4:0]    w_sh;
    logic [31:0]   w_treq;
    logic [PW-1:0] w_tclamp;
    logic          w_rwe;
    logic [IW-1:0] w_rwaddr;
    logic [PW-1:0] w_rwdata, w_rlen;
    t_tree_stat    w_tstat;
    logic [IW-1:0] w_tstart;

    assign w_sh = (r_psl > MAX_LOG2) ? MAX_LOG2 : r_psl;

    // Page count from the low 12 bits of the written data, limited to 1..MAX_PAGES
    assign w_treq   = {20'd0, i_cfg_data[11:0]};
    assign w_tclamp = (w_treq == 32'd0) ? PW'(1) :
                      (w_treq > 32'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(w_treq);

    // Run length store write port: clearing pass or record update
    always_comb begin
        w_rwe    = 1'b0;
        w_rwaddr = r_ua;
        w_rwdata = '0;
        if (r_state == T_CLEAR) begin
            w_rwe    = 1'b1;
            w_rwaddr = r_clr;
        end else if (r_state == T_UPD && w_tstat.done) begin
            w_rwe    = 1'b1;
            w_rwdata = (r_op == OP_ALLOC) ? PW'(r_need) : '0;
        end
    end

    cpra_ram #(.W(PW), .D(MAX_PAGES)) u_run_ram (
        .i_clk  (i_clk),
        .i_we   (w_rwe),
        .i_waddr(w_rwaddr),
        .i_wdata(w_rwdata),
        .i_raddr(r_pg[IW-1:0]),
        .o_rdata(w_rlen)
    );

    cpra_tree #(.MAX_PAGES(MAX_PAGES)) u_tree (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_init (r_init),
        .i_go   (r_go),
        .i_op   (r_top),
        .i_need (PW'(r_need)),
        .i_total(r_total),
        .i_lo   (r_ua),
        .i_hi   (r_ub),
        .i_tag  (r_utag),
        .o_stat (w_tstat),
        .o_start(w_tstart)
    );

    assign o_in_stall  = (r_state != T_IDLE);
    assign o_out_valid = r_ov;
    assign o_address   = r_oaddr;
    assign o_failed    = r_ofail;

    // Request sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_CLEAR;
            r_clr   <= '0;
            r_init  <= 1'b1;
            r_go    <= 1'b0;
            r_ov    <= 1'b0;
            r_base  <= '0;
            r_psl   <= 5'd12;
            r_total <= PW'(TOTAL_RST);
        end else begin
            r_init <= 1'b0;
            r_go   <= 1'b0;
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                T_CLEAR: begin
                    r_clr <= r_clr + IW'(1);
                    if (r_clr == IW'(MAX_PAGES - 1)) begin
                        r_state <= T_IDLE;
                    end
                end
                T_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_operation;
                        r_bytes <= i_request_bytes;
                        r_faddr <= i_free_address;
                        r_state <= T_PREP;
                    end
                end
                T_PREP: begin
                    r_need  <= ({1'b0, r_bytes} + (33'd1 << w_sh) - 33'd1) >> w_sh;
                    r_pg    <= (r_faddr - r_base) >> w_sh;
                    r_state <= T_CHK;
                end
                T_CHK: begin
                    r_res_addr <= '0;
                    r_res_fail <= 1'b0;
                    if (r_op == OP_ALLOC) begin
                        if (r_need == 33'd0 || r_need > 33'(r_total)) begin
                            r_res_fail <= 1'b1;
                            r_state    <= T_DONE;
                        end else begin
                            r_go    <= 1'b1;
                            r_top   <= TOP_SEARCH;
                            r_state <= T_SRCH;
                        end
                    end else if (r_pg >= 32'(r_total)) begin
                        r_state <= T_DONE;
                    end else begin
                        r_state <= T_FLEN;
                    end
                end
                T_FLEN: begin
                    if (w_rlen == '0) begin
                        r_state <= T_DONE;
                    end else begin
                        r_ua    <= r_pg[IW-1:0];
                        r_ub    <= IW'(r_pg[IW-1:0] + w_rlen - PW'(1));
                        r_utag  <= TAG_FREE;
                        r_go    <= 1'b1;
                        r_top   <= TOP_UPDATE;
                        r_state <= T_UPD;
                    end
                end
                T_SRCH: begin
                    if (w_tstat.done) begin
                        if (!w_tstat.found) begin
                            r_res_fail <= 1'b1;
                            r_state    <= T_DONE;
                        end else begin
                            r_ua    <= w_tstart;
                            r_ub    <= IW'(w_tstart + r_need[IW-1:0] - IW'(1));
                            r_utag  <= TAG_USED;
                            r_go    <= 1'b1;
                            r_top   <= TOP_UPDATE;
                            r_state <= T_UPD;
                        end
                    end
                end
                T_UPD: begin
                    if (w_tstat.done) begin
                        if (r_op == OP_ALLOC) begin
                            r_res_addr <= r_base + ({{(32 - IW){1'b0}}, r_ua} << w_sh);
                        end
                        r_state <= T_DONE;
                    end
                end
                T_DONE: begin
                    if (!r_ov || !i_out_stall) begin
                        r_ov    <= 1'b1;
                        r_oaddr <= r_res_addr;
                        r_ofail <= r_res_fail;
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
            // Configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE: r_base <= i_cfg_data;
                    CFG_PSL:  r_psl  <= i_cfg_data[4:0];
                    CFG_TOTAL: begin
                        r_total <= w_tclamp;
                        r_init  <= 1'b1;
                        r_clr   <= '0;
                        r_state <= T_CLEAR;
                    end
                    default: r_psl <= r_psl;
                endcase
            end
        end
    end

    // Tree completions only arrive while a walk is awaited
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tstat.done |-> (r_state == T_SRCH || r_state == T_UPD))
        else $error("tree completion outside a walk");

    // Tree engine idle whenever no request is in flight
    a_tree_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_IDLE || r_state == T_CLEAR) |-> !w_tstat.busy)
        else $error("tree engine busy while idle");

    // A failed result never carries an address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_failed) |-> (o_address == 32'd0))
        else $error("failed result with non-zero address");

    // A new result is only loaded once the previous one has gone
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_address))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== rtl/core/cpra_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module cpra_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = $clog2(D)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/cpra_tree.sv =====
// Segment tree engine: longest free run search and lazy range cover over a node RAM.
`default_nettype none
module cpra_tree
    import cpra_pkg::*;
#(
    parameter int MAX_PAGES = 2048,
    localparam int PW = $clog2(MAX_PAGES + 1),
    localparam int IW = $clog2(MAX_PAGES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_init,
    input  wire logic          i_go,
    input  wire logic          i_op,
    input  wire logic [PW-1:0] i_need,
    input  wire logic [PW-1:0] i_total,
    input  wire logic [IW-1:0] i_lo,
    input  wire logic [IW-1:0] i_hi,
    input  wire logic [1:0]    i_tag,
    output t_tree_stat         o_stat,
    output logic      [IW-1:0] o_start
);

    localparam int NW = $clog2(4 * MAX_PAGES);
    localparam int WW = 3 * PW + 2;
    localparam int SD = IW + 1;
    localparam int DW = $clog2(SD);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_VISIT  = 4'd1;
    localparam logic [3:0] S_SVISIT = 4'd2;
    localparam logic [3:0] S_PD     = 4'd3;
    localparam logic [3:0] S_PDWA   = 4'd4;
    localparam logic [3:0] S_PDWB   = 4'd5;
    localparam logic [3:0] S_PDWP   = 4'd6;
    localparam logic [3:0] S_PDEND  = 4'd7;
    localparam logic [3:0] S_SRA    = 4'd8;
    localparam logic [3:0] S_SRB    = 4'd9;
    localparam logic [3:0] S_LEAF   = 4'd10;
    localparam logic [3:0] S_UP     = 4'd11;
    localparam logic [3:0] S_PURB   = 4'd12;
    localparam logic [3:0] S_PUC    = 4'd13;
    localparam logic [3:0] S_PUW    = 4'd14;

    // Node word: {longest, prefix, suffix, tag}
    function automatic logic [PW-1:0] f_lng(input logic [WW-1:0] w);
        return w[WW-1 -: PW];
    endfunction
    function automatic logic [PW-1:0] f_pre(input logic [WW-1:0] w);
        return w[WW-1-PW -: PW];
    endfunction
    function automatic logic [PW-1:0] f_suf(input logic [WW-1:0] w);
        return w[PW+1 -: PW];
    endfunction
    function automatic logic [WW-1:0] f_cov(input logic [1:0] tag, input logic [PW-1:0] sz);
        logic [PW-1:0] v;
        v = (tag == TAG_USED) ? '0 : sz;
        return {v, v, v, tag};
    endfunction

    logic [3:0]    r_st;
    logic          r_op;
    logic [PW-1:0] r_need;
    logic [IW-1:0] r_ua, r_ub;
    logic [1:0]    r_tag;
    logic [NW-1:0] r_node;
    logic [IW-1:0] r_lo, r_hi;
    logic [DW-1:0] r_depth;
    logic [1:0]    r_pt;
    logic [WW-1:0] r_nd, r_a, r_b;
    logic          r_done, r_found;
    logic [IW-1:0] r_start;
    logic [IW-1:0] r_slo [SD];
    logic [IW-1:0] r_shi [SD];

    logic          w_we;
    logic [NW-1:0] w_waddr, w_raddr;
    logic [WW-1:0] w_wdata, w_rdata;

    logic [IW-1:0] w_mid, w_plo, w_phi, w_pmid;
    logic [PW-1:0] w_sza, w_szb, w_sz;
    logic [DW-1:0] w_dm1;
    logic [NW-1:0] w_ca, w_cb;
    logic          w_disj, w_covd;
    logic [PW:0]   w_across;
    logic [PW-1:0] w_ppre, w_psuf, w_pbest, w_plng;
    logic [PW-1:0] w_pacr;

    // Range geometry of the current node and its parent
    assign w_mid  = r_lo + ((r_hi - r_lo) >> 1);
    assign w_sza  = PW'(w_mid - r_lo) + PW'(1);
    assign w_szb  = PW'(r_hi - w_mid);
    assign w_sz   = PW'(r_hi - r_lo) + PW'(1);
    assign w_dm1  = r_depth - DW'(1);
    assign w_plo  = r_slo[w_dm1];
    assign w_phi  = r_shi[w_dm1];
    assign w_pmid = w_plo + ((w_phi - w_plo) >> 1);
    assign w_ca   = {r_node[NW-2:0], 1'b0};
    assign w_cb   = {r_node[NW-2:0], 1'b1};
    assign w_disj = (r_ub < r_lo) || (r_ua > r_hi);
    assign w_covd = (r_ua <= r_lo) && (r_hi <= r_ub);

    // Straddling run for the search, children in r_a and read data
    assign w_across = {1'b0, f_suf(r_a)} + {1'b0, f_pre(w_rdata)};

    // Pull-up from both children held in r_a and r_b
    assign w_ppre  = (f_lng(r_a) == w_sza) ? w_sza + f_pre(r_b) : f_pre(r_a);
    assign w_psuf  = (f_lng(r_b) == w_szb) ? w_szb + f_suf(r_a) : f_suf(r_b);
    assign w_pbest = (f_lng(r_a) > f_lng(r_b)) ? f_lng(r_a) : f_lng(r_b);
    assign w_pacr  = f_suf(r_a) + f_pre(r_b);
    assign w_plng  = (w_pacr > w_pbest) ? w_pacr : w_pbest;

    // Node RAM port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_node;
        w_wdata = f_cov(r_tag, w_sz);
        case (r_st)
            S_PDEND: w_raddr = w_ca;
            S_SRA:   w_raddr = w_cb;
            S_UP:    w_raddr = {r_node[NW-1:1], 1'b0};
            S_PURB:  w_raddr = w_cb;
            default: w_raddr = r_node;
        endcase
        case (r_st)
            S_IDLE: begin
                if (i_init) begin
                    w_we    = 1'b1;
                    w_waddr = NW'(1);
                    w_wdata = f_cov(TAG_FREE, i_total);
                end
            end
            S_VISIT: begin
                w_we = !w_disj && w_covd;
            end
            S_PDWA: begin
                w_we    = 1'b1;
                w_waddr = w_ca;
                w_wdata = f_cov(r_pt, w_sza);
            end
            S_PDWB: begin
                w_we    = 1'b1;
                w_waddr = w_cb;
                w_wdata = f_cov(r_pt, w_szb);
            end
            S_PDWP: begin
                w_we    = 1'b1;
                w_wdata = {r_nd[WW-1:2], TAG_NONE};
            end
            S_PUW: begin
                w_we    = 1'b1;
                w_wdata = {w_plng, w_ppre, w_psuf, TAG_NONE};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    cpra_ram #(.W(WW), .D(4 * MAX_PAGES)) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Walk sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_done  <= 1'b0;
            r_found <= 1'b0;
            r_depth <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_go && !i_init) begin
                        r_op    <= i_op;
                        r_need  <= i_need;
                        r_ua    <= i_lo;
                        r_ub    <= i_hi;
                        r_tag   <= i_tag;
                        r_node  <= NW'(1);
                        r_lo    <= '0;
                        r_hi    <= IW'(i_total - PW'(1));
                        r_depth <= '0;
                        r_st    <= (i_op == TOP_SEARCH) ? S_SVISIT : S_VISIT;
                    end
                end
                S_VISIT: begin
                    if (w_disj || w_covd) begin
                        r_st <= S_UP;
                    end else begin
                        r_st <= S_PD;
                    end
                end
                S_SVISIT: begin
                    r_st <= (r_lo == r_hi) ? S_LEAF : S_PD;
                end
                S_PD: begin
                    r_pt <= w_rdata[1:0];
                    r_nd <= w_rdata;
                    if (w_rdata[1:0] == TAG_USED || w_rdata[1:0] == TAG_FREE) begin
                        r_st <= S_PDWA;
                    end else begin
                        r_st <= S_PDEND;
                    end
                end
                S_PDWA: r_st <= S_PDWB;
                S_PDWB: r_st <= S_PDWP;
                S_PDWP: r_st <= S_PDEND;
                S_PDEND: begin
                    if (r_op == TOP_SEARCH) begin
                        r_st <= S_SRA;
                    end else begin
                        // descend left, remember this node's range
                        r_slo[r_depth] <= r_lo;
                        r_shi[r_depth] <= r_hi;
                        r_depth        <= r_depth + DW'(1);
                        r_node         <= w_ca;
                        r_hi           <= w_mid;
                        r_st           <= S_VISIT;
                    end
                end
                S_SRA: begin
                    r_a  <= w_rdata;
                    r_st <= S_SRB;
                end
                S_SRB: begin
                    if (f_lng(r_a) >= r_need) begin
                        r_node <= w_ca;
                        r_hi   <= w_mid;
                        r_st   <= S_SVISIT;
                    end else if (f_lng(w_rdata) >= r_need) begin
                        r_node <= w_cb;
                        r_lo   <= w_mid + IW'(1);
                        r_st   <= S_SVISIT;
                    end else begin
                        r_found <= (w_across >= {1'b0, r_need});
                        r_start <= w_mid + IW'(1) - IW'(f_suf(r_a));
                        r_done  <= 1'b1;
                        r_st    <= S_IDLE;
                    end
                end
                S_LEAF: begin
                    r_found <= (f_lng(w_rdata) >= r_need);
                    r_start <= r_lo;
                    r_done  <= 1'b1;
                    r_st    <= S_IDLE;
                end
                S_UP: begin
                    if (r_depth == '0) begin
                        r_found <= 1'b1;
                        r_done  <= 1'b1;
                        r_st    <= S_IDLE;
                    end else if (!r_node[0]) begin
                        // left child finished: visit its sibling
                        r_node[0] <= 1'b1;
                        r_lo      <= w_pmid + IW'(1);
                        r_hi      <= w_phi;
                        r_st      <= S_VISIT;
                    end else begin
                        // right child finished: rebuild the parent
                        r_node  <= {1'b0, r_node[NW-1:1]};
                        r_lo    <= w_plo;
                        r_hi    <= w_phi;
                        r_depth <= w_dm1;
                        r_st    <= S_PURB;
                    end
                end
                S_PURB: begin
                    r_a  <= w_rdata;
                    r_st <= S_PUC;
                end
                S_PUC: begin
                    r_b  <= w_rdata;
                    r_st <= S_PUW;
                end
                S_PUW: r_st <= S_UP;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_stat  = '{busy: (r_st != S_IDLE), done: r_done, found: r_found};
    assign o_start = r_start;

endmodule
`default_nettype wire
